@@ hw/rtl/best_fit_allocator_core_assert.svh @@
// Assertion macros used by the checker file of the allocator.
`ifndef BEST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

@@ hw/rtl/bfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

   localparam int MEM_UNITS = 64;
   localparam int ADDR_W    = $clog2(MEM_UNITS);
   localparam int LEN_W     = $clog2(MEM_UNITS + 1);
   localparam int SUM_W     = LEN_W + 1;

   typedef enum logic {
      OP_ALLOCATE = 1'b0,
      OP_FREE     = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_FIT      = 2'd1,
      STATUS_BAD_ADDRESS = 2'd2,
      STATUS_ZERO_SIZE   = 2'd3
   } status_type;

   typedef struct packed {
      operation_type     operation;
      logic [LEN_W-1:0]  request_size;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] start_address;
      logic [LEN_W-1:0]  block_length;
   } rsp_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_CHECK,
      STATE_SCAN,
      STATE_COMMIT,
      STATE_FREE
   } state_type;

   typedef enum logic [2:0] {
      RSP_ALLOC_OK,
      RSP_FREE_OK,
      RSP_NO_FIT,
      RSP_BAD_ADDRESS,
      RSP_ZERO_SIZE
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         scan_init;
      logic         scan_step;
      logic         alloc_commit;
      logic         free_commit;
      logic         respond;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic is_free_op;
      logic zero_size;
      logic is_block_start;
      logic scan_last;
      logic found;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/best_fit_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Best-fit allocator over a pool of 64 allocation units, all free after reset.
// A request beat is taken at a rising edge where start is high and busy is low.
// An allocate request carries request_size and returns the start of the
// smallest free run that holds it, lowest address on ties; a free request
// carries block_address and releases the block that starts there.
// Each request gives exactly one response beat: rsp_valid is high for one
// cycle with status, start_address and block_length on rsp_payload.
// An allocate of nonzero size passes through the check, scan and commit
// states and walks the usage map one unit per clock in the scan state; a
// new request may be taken in the cycle the response is shown.
// A free passes through the check and free states, limited by the registered
// read of the block length memory; error responses come from the check state.
// Synchronous reset marks every unit free and clears all block starts.
// The receiver cannot stall: each response is shown for one cycle only.

module best_fit_allocator_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bfa_pkg::req_type req_payload,
   output logic                  rsp_valid,
   output bfa_pkg::rsp_type      rsp_payload
);

   import bfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bfa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   bfa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

@@ hw/rtl/bfa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bfa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bfa_pkg::stat_type stat,
   output bfa_pkg::cmd_type       cmd
);

   import bfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_kind = RSP_ALLOC_OK;
      busy     = 1'b1;
      unique case (state_ff)
         STATE_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = STATE_CHECK;
            end
         end
         STATE_CHECK: begin
            if (stat.is_free_op) begin
               if (stat.is_block_start) begin
                  state_in = STATE_FREE;
               end else begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_kind = RSP_BAD_ADDRESS;
                  state_in     = STATE_IDLE;
               end
            end else if (stat.zero_size) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RSP_ZERO_SIZE;
               state_in     = STATE_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = STATE_COMMIT;
            end
         end
         STATE_COMMIT: begin
            cmd.respond = 1'b1;
            if (stat.found) begin
               cmd.alloc_commit = 1'b1;
               cmd.rsp_kind     = RSP_ALLOC_OK;
            end else begin
               cmd.rsp_kind = RSP_NO_FIT;
            end
            state_in = STATE_IDLE;
         end
         STATE_FREE: begin
            cmd.free_commit = 1'b1;
            cmd.respond     = 1'b1;
            cmd.rsp_kind    = RSP_FREE_OK;
            state_in        = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/bfa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfa_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bfa_pkg::req_type req_payload,
   input  wire bfa_pkg::cmd_type cmd,
   output bfa_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output bfa_pkg::rsp_type      rsp_payload
);

   import bfa_pkg::*;

   req_type             req_ff;
   logic [MEM_UNITS-1:0] used_map_ff, used_map_in;
   logic [MEM_UNITS-1:0] start_map_ff, start_map_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   run_start_ff, run_start_in;
   logic [LEN_W-1:0]    run_len_ff, run_len_in;
   logic [ADDR_W-1:0]   best_start_ff, best_start_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   logic                unit_free;
   logic                scan_last;
   logic                cand_valid;
   logic [LEN_W-1:0]    cand_len;
   logic [ADDR_W-1:0]   cand_start;
   logic                take;
   logic [LEN_W-1:0]    stored_len;
   logic [ADDR_W-1:0]   range_lo;
   logic [LEN_W-1:0]    range_len;
   logic [SUM_W-1:0]    range_end;
   logic [MEM_UNITS-1:0] range_mask;

   bfa_ram #(
      .WIDTH(LEN_W),
      .DEPTH(MEM_UNITS)
   ) u_length_ram (
      .clock  (clock),
      .wr_en  (cmd.alloc_commit),
      .wr_addr(best_start_ff),
      .wr_data(req_ff.request_size),
      .rd_addr(req_ff.block_address),
      .rd_data(stored_len)
   );

   assign unit_free = !used_map_ff[idx_ff];
   assign scan_last = (idx_ff == ADDR_W'(MEM_UNITS - 1));

   assign stat.is_free_op     = (req_ff.operation == OP_FREE);
   assign stat.zero_size      = (req_ff.request_size == '0);
   assign stat.is_block_start = start_map_ff[req_ff.block_address];
   assign stat.scan_last      = scan_last;
   assign stat.found          = found_ff;

   always_comb begin
      idx_in        = idx_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      found_in      = found_ff;
      cand_valid    = 1'b0;
      cand_len      = run_len_ff;
      cand_start    = run_start_ff;
      take          = 1'b0;
      if (cmd.scan_init) begin
         idx_in     = '0;
         run_len_in = '0;
         found_in   = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + 1'b1;
         if (unit_free) begin
            run_start_in = (run_len_ff == '0) ? idx_ff : run_start_ff;
            run_len_in   = run_len_ff + 1'b1;
            cand_valid   = scan_last;
            cand_len     = run_len_in;
            cand_start   = run_start_in;
         end else begin
            run_len_in = '0;
            cand_valid = (run_len_ff != '0);
         end
         take = cand_valid && (cand_len >= req_ff.request_size)
                && (!found_ff || (cand_len < best_len_ff));
         if (take) begin
            found_in      = 1'b1;
            best_start_in = cand_start;
            best_len_in   = cand_len;
         end
      end
   end

   always_comb begin
      range_lo  = cmd.free_commit ? req_ff.block_address : best_start_ff;
      range_len = cmd.free_commit ? stored_len : req_ff.request_size;
      range_end = SUM_W'(range_lo) + SUM_W'(range_len);
      for (int j = 0; j < MEM_UNITS; j++) begin
         range_mask[j] = (SUM_W'(j) >= SUM_W'(range_lo)) && (SUM_W'(j) < range_end);
      end
   end

   always_comb begin
      used_map_in  = used_map_ff;
      start_map_in = start_map_ff;
      if (cmd.alloc_commit) begin
         used_map_in                = used_map_ff | range_mask;
         start_map_in[best_start_ff] = 1'b1;
      end else if (cmd.free_commit) begin
         used_map_in                        = used_map_ff & ~range_mask;
         start_map_in[req_ff.block_address] = 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_kind)
         RSP_ALLOC_OK: begin
            rsp_in.status        = STATUS_OK;
            rsp_in.start_address = best_start_ff;
            rsp_in.block_length  = req_ff.request_size;
         end
         RSP_FREE_OK: begin
            rsp_in.status        = STATUS_OK;
            rsp_in.start_address = req_ff.block_address;
            rsp_in.block_length  = stored_len;
         end
         RSP_NO_FIT:      rsp_in.status = STATUS_NO_FIT;
         RSP_BAD_ADDRESS: rsp_in.status = STATUS_BAD_ADDRESS;
         RSP_ZERO_SIZE:   rsp_in.status = STATUS_ZERO_SIZE;
         default:         rsp_in.status = STATUS_NO_FIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_map_ff  <= '0;
         start_map_ff <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_map_ff  <= used_map_in;
         start_map_ff <= start_map_in;
         found_ff     <= found_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
      idx_ff        <= idx_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bfa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "best_fit_allocator_core_assert.svh"

module bfa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire bfa_pkg::rsp_type rsp_payload
);

   import bfa_pkg::*;

   logic req_beat;
   logic rsp_ok;
   logic rsp_zeroed;

   assign req_beat   = start && !busy;
   assign rsp_ok     = rsp_valid && (rsp_payload.status == STATUS_OK);
   assign rsp_zeroed = (rsp_payload.start_address == '0) && (rsp_payload.block_length == '0);

   `BFA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, busy)
   `BFA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `BFA_ASSERT_SAME(a_rsp_follows_work, clock, reset, rsp_valid, $past(busy))
   `BFA_ASSERT_SAME(a_error_zeroed, clock, reset, rsp_valid && !rsp_ok, rsp_zeroed)
   `BFA_ASSERT_SAME(a_ok_nonempty, clock, reset, rsp_ok, rsp_payload.block_length != '0)

endmodule

bind best_fit_allocator_core bfa_checker u_bfa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_payload(rsp_payload)
);

`default_nettype wire

@@ bench/best_fit_allocator_core_test.sv @@
`timescale 1ns / 1ps

module best_fit_allocator_core_test;
   import bfa_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BEATS = 400;

   typedef struct packed {
      logic [MEM_UNITS-1:0]            used;
      logic [MEM_UNITS-1:0]            starts;
      logic [MEM_UNITS-1:0][LEN_W-1:0] lengths;
   } pool_type;

   typedef struct packed {
      logic    wait_idle;
      req_type req;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   pool_type    plan_pool = '0;
   pool_type    model_pool = '0;
   pending_type pending_beats[$];
   rsp_type     expected_rsp[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          gap_left = 0;
   int          burst_left = 0;

   best_fit_allocator_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Computes the response to one request and the pool as it stands afterwards.
   function automatic rsp_type serve_request(input pool_type pool, input req_type req,
                                             output pool_type after);
      rsp_type rsp;
      int      i;
      int      size;
      int      run_start;
      int      run_len;
      int      best_start;
      int      best_len;
      bit      found;
      rsp = '0;
      rsp.status = STATUS_OK;
      after = pool;
      size = req.request_size;
      if (req.operation == OP_ALLOCATE) begin
         if (size == 0) begin
            rsp.status = STATUS_ZERO_SIZE;
         end else begin
            found = 1'b0;
            run_start = 0;
            run_len = 0;
            best_start = 0;
            best_len = 0;
            for (i = 0; i <= MEM_UNITS; i++) begin
               if (i < MEM_UNITS && !pool.used[i % MEM_UNITS]) begin
                  if (run_len == 0) run_start = i;
                  run_len++;
               end else begin
                  if (run_len >= size && (!found || run_len < best_len)) begin
                     found = 1'b1;
                     best_start = run_start;
                     best_len = run_len;
                  end
                  run_len = 0;
               end
            end
            if (!found) begin
               rsp.status = STATUS_NO_FIT;
            end else begin
               for (i = best_start; i < best_start + size; i++) after.used[i] = 1'b1;
               after.starts[best_start] = 1'b1;
               after.lengths[best_start] = size[LEN_W-1:0];
               rsp.start_address = best_start[ADDR_W-1:0];
               rsp.block_length = size[LEN_W-1:0];
            end
         end
      end else if (!pool.starts[req.block_address]) begin
         rsp.status = STATUS_BAD_ADDRESS;
      end else begin
         for (i = 0; i < pool.lengths[req.block_address] && req.block_address + i < MEM_UNITS;
              i++)
            after.used[req.block_address + i] = 1'b0;
         after.starts[req.block_address] = 1'b0;
         rsp.start_address = req.block_address;
         rsp.block_length = pool.lengths[req.block_address];
      end
      return rsp;
   endfunction

   task automatic queue_request(input operation_type op, input int size, input int addr,
                                input logic wait_idle);
      pending_type item;
      pool_type    next_pool;
      rsp_type     ignored;
      item.wait_idle = wait_idle;
      item.req.operation = op;
      item.req.request_size = size[LEN_W-1:0];
      item.req.block_address = addr[ADDR_W-1:0];
      ignored = serve_request(plan_pool, item.req, next_pool);
      plan_pool = next_pool;
      pending_beats.push_back(item);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : stimulus
      int n;
      int pick;
      int addr;
      int i;
      int live_starts[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_request(OP_ALLOCATE, 0, 45, 1'b0);
      queue_request(OP_ALLOCATE, 64, 0, 1'b0);
      queue_request(OP_ALLOCATE, 1, 0, 1'b0);
      queue_request(OP_FREE, 0, 63, 1'b0);
      queue_request(OP_FREE, 127, 0, 1'b0);
      queue_request(OP_FREE, 0, 0, 1'b0);
      queue_request(OP_ALLOCATE, 127, 63, 1'b0);
      queue_request(OP_ALLOCATE, 65, 0, 1'b0);
      queue_request(OP_ALLOCATE, 8, 0, 1'b0);
      queue_request(OP_ALLOCATE, 8, 0, 1'b0);
      queue_request(OP_ALLOCATE, 8, 0, 1'b0);
      queue_request(OP_ALLOCATE, 8, 0, 1'b0);
      queue_request(OP_FREE, 0, 8, 1'b0);
      queue_request(OP_FREE, 0, 24, 1'b0);
      queue_request(OP_ALLOCATE, 8, 63, 1'b0);
      queue_request(OP_FREE, 0, 16, 1'b0);
      queue_request(OP_FREE, 0, 0, 1'b0);
      queue_request(OP_ALLOCATE, 4, 0, 1'b0);
      queue_request(OP_FREE, 64, 5, 1'b0);
      queue_request(OP_ALLOCATE, 48, 0, 1'b0);
      queue_request(OP_FREE, 127, 16, 1'b0);
      queue_request(OP_FREE, 0, 8, 1'b0);
      queue_request(OP_ALLOCATE, 60, 0, 1'b0);
      queue_request(OP_FREE, 0, 0, 1'b0);
      queue_request(OP_FREE, 0, 4, 1'b0);

      // Two holes of equal length ahead of a larger one: the lower hole must win.
      queue_request(OP_ALLOCATE, 10, 0, 1'b1);
      queue_request(OP_ALLOCATE, 1, 0, 1'b0);
      queue_request(OP_ALLOCATE, 10, 0, 1'b0);
      queue_request(OP_ALLOCATE, 1, 0, 1'b0);
      queue_request(OP_FREE, 0, 0, 1'b0);
      queue_request(OP_FREE, 0, 11, 1'b0);
      queue_request(OP_ALLOCATE, 10, 0, 1'b0);

      for (n = 0; n < RANDOM_BEATS; n++) begin
         live_starts.delete();
         for (i = 0; i < MEM_UNITS; i++)
            if (plan_pool.starts[i]) live_starts.push_back(i);
         pick = $urandom_range(99);
         if (pick < (($countones(plan_pool.used) > 48) ? 25 : 55)) begin
            pick = $urandom_range(99);
            if (pick < 3) addr = 0;
            else if (pick < 8) addr = $urandom_range(127, 65);
            else if (pick < 20) addr = $urandom_range(64, 13);
            else addr = $urandom_range(12, 1);
            queue_request(OP_ALLOCATE, addr, $urandom_range(63),
                          (n == 0) || ($urandom_range(49) == 0));
         end else begin
            if (live_starts.size() > 0 && $urandom_range(9) < 8)
               addr = live_starts[$urandom_range(live_starts.size() - 1)];
            else
               addr = $urandom_range(63);
            queue_request(OP_FREE, $urandom_range(127), addr, $urandom_range(49) == 0);
         end
      end

      while (pending_beats.size() > 0 || start || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   always @(posedge clock) begin : drive
      logic        take;
      pending_type item;
      pool_type    next_pool;
      rsp_type     rsp;
      if (reset) begin
         start <= 1'b0;
         req_payload <= '0;
      end else begin
         take = start && !busy;
         if (take) begin
            rsp = serve_request(model_pool, req_payload, next_pool);
            model_pool = next_pool;
            expected_rsp.push_back(rsp);
         end
         if (!start || take) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].wait_idle && expected_rsp.size() > 0)) begin
               item = pending_beats.pop_front();
               req_payload <= item.req;
               start <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(12);
                  case ($urandom_range(3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(90, 1);
                     default: gap_left = $urandom_range(8, 1);
                  endcase
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response beat st=%0d addr=%0d len=%0d", $realtime,
                        rsp_payload.status, rsp_payload.start_address,
                        rsp_payload.block_length);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.start_address !== want.start_address ||
                rsp_payload.block_length !== want.block_length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response mismatch, expected st=%0d addr=%0d len=%0d, got st=%0d addr=%0d len=%0d",
                           $realtime, want.status, want.start_address, want.block_length,
                           rsp_payload.status, rsp_payload.start_address,
                           rsp_payload.block_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
